FILE: rtl/fir16_pkg.sv
`default_nettype none

package fir16_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 8;
    localparam int NUM_TAPS_W = 9;

    localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RESET = 9'd201;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

    typedef struct packed {
        logic                         req_type;
        logic signed [SAMPLE_W-1:0]   sample_in;
        logic        [COEF_IDX_W-1:0] coef_index;
        logic signed [COEF_W-1:0]     coef_value;
    } s_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } m_res_t;

    // load: shift a new sample into the line; rotate: turn both rings one cell
    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/fir16_cell.sv
`default_nettype none

module fir16_cell
    import fir16_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cell_ctrl_t                 ctrl,
    input  wire logic                       coef_we,
    input  wire logic signed [COEF_W-1:0]   coef_wdata,
    input  wire logic signed [SAMPLE_W-1:0] load_sample,
    input  wire logic signed [SAMPLE_W-1:0] rot_sample,
    input  wire logic signed [COEF_W-1:0]   rot_coef,
    output logic signed [SAMPLE_W-1:0]      sample_q,
    output logic signed [COEF_W-1:0]        coef_q
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [COEF_W-1:0]   coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (ctrl.load) begin
            sample_reg <= load_sample;
        end else if (ctrl.rotate) begin
            sample_reg <= rot_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rotate) begin
            coef_reg <= rot_coef;
        end else if (coef_we) begin
            coef_reg <= coef_wdata;
        end
    end

    assign sample_q = sample_reg;
    assign coef_q   = coef_reg;

endmodule

`default_nettype wire

FILE: rtl/fir16_mac.sv
`default_nettype none

module fir16_mac
    import fir16_pkg::*;
#(
    parameter int ACC_W = 40
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mac_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [COEF_W-1:0]   coef,
    output logic signed [ACC_W-1:0]         acc
);

    localparam int PROD_W = SAMPLE_W + COEF_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(sample * coef);
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/fir_filter_16bit_audio_top.sv
`default_nettype none
// A sample request is accepted only in IDLE, and no new request is taken until its result
// is handed over: the single multiply-accumulate is fed from the head of the rotating
// sample/coefficient ring (one tap per cycle) in RUN, then DRAIN, then DONE.
// Coefficient requests are accepted in IDLE, leave the block there and give no result.
// Reset (aresetn, synchronous, active low) zeroes the delay line, sets num_taps to 201
// and leaves the coefficients as they are.

module fir_filter_16bit_audio_top
    import fir16_pkg::*;
#(
    parameter int MAX_TAPS       = 256,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [NUM_TAPS_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire s_req_t                s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output m_res_t                     m_data
);

    localparam int STEP_W = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = SAMPLE_W + COEF_W + $clog2(MAX_TAPS);

    localparam logic signed [ACC_W-1:0] ROUND_ADD =
        ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);

    typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_t;

    state_t                  state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [NUM_TAPS_W-1:0]   num_taps_reg;
    logic                    m_valid_reg;
    m_res_t                  m_data_reg;

    logic                    accept;
    logic                    issue;
    cell_ctrl_t              cell_ctrl;
    mac_ctrl_t               mac_ctrl;
    logic                    coef_wr;
    logic [CNT_W-1:0]        taps_eff;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_adj;
    logic signed [ACC_W-1:0] quot;
    m_res_t                  result;

    logic signed [SAMPLE_W-1:0] cell_sample [MAX_TAPS];
    logic signed [COEF_W-1:0]   cell_coef   [MAX_TAPS];

    assign s_ready = (state_reg == IDLE);
    assign accept  = s_valid && s_ready;

    assign cell_ctrl.load   = accept && (s_data.req_type == REQ_SAMPLE);
    assign cell_ctrl.rotate = (state_reg == RUN);
    assign coef_wr          = accept && (s_data.req_type == REQ_COEF);

    // hand the result over once the output register frees up
    assign issue = (state_reg == DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        if (num_taps_reg == '0) begin
            taps_eff = CNT_W'(1);
        end else if (32'(num_taps_reg) > MAX_TAPS) begin
            taps_eff = CNT_W'(MAX_TAPS);
        end else begin
            taps_eff = CNT_W'(num_taps_reg);
        end
    end

    assign mac_ctrl.clear = cell_ctrl.load;
    assign mac_ctrl.en    = (state_reg == RUN) && (CNT_W'(step_reg) < taps_eff);

    // ring of cells: load shifts toward the tail, rotate pulls from the next cell
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
        logic signed [SAMPLE_W-1:0] load_sample;
        logic                       coef_we;

        if (i == 0) begin : g_head
            assign load_sample = s_data.sample_in;
        end else begin : g_body
            assign load_sample = cell_sample[i-1];
        end

        assign coef_we = coef_wr && (32'(s_data.coef_index) == i);

        fir16_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .coef_we     (coef_we),
            .coef_wdata  (s_data.coef_value),
            .load_sample (load_sample),
            .rot_sample  (cell_sample[(i + 1) % MAX_TAPS]),
            .rot_coef    (cell_coef[(i + 1) % MAX_TAPS]),
            .sample_q    (cell_sample[i]),
            .coef_q      (cell_coef[i])
        );
    end

    fir16_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .sample  (cell_sample[0]),
        .coef    (cell_coef[0]),
        .acc     (acc)
    );

    // scale down, truncating toward zero, then clip
    always_comb begin
        acc_adj = acc + (acc[ACC_W-1] ? ROUND_ADD : '0);
        quot    = acc_adj >>> COEF_FRAC_BITS;
        priority if (quot > ACC_MAX) begin
            result.sample_out = OUT_MAX;
            result.saturated  = 1'b1;
        end else if (quot < ACC_MIN) begin
            result.sample_out = OUT_MIN;
            result.saturated  = 1'b1;
        end else begin
            result.sample_out = quot[SAMPLE_W-1:0];
            result.saturated  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= NUM_TAPS_RESET;
        end else if (cfg_wr_en) begin
            num_taps_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= result;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (cell_ctrl.load) begin
                        step_reg  <= '0;
                        state_reg <= RUN;
                    end
                end
                RUN: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MAX_TAPS - 1)) begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN: begin
                    state_reg <= DONE;
                end
                DONE: begin
                    // hold the result until the output register frees up
                    if (issue) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/fir16_checker.sv
`default_nettype none

module fir16_checker
    import fir16_pkg::*;
(
    input wire logic   aclk,
    input wire logic   aresetn,
    input wire logic   s_valid,
    input wire logic   s_ready,
    input wire s_req_t s_data,
    input wire logic   m_valid,
    input wire logic   m_ready,
    input wire m_res_t m_data
);

    // a result waiting for the sink holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_coef_no_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_COEF) |=> s_ready)
        else $error("coefficient request left the block busy");

    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_SAMPLE) |=> !s_ready)
        else $error("sample request did not start the filter");

    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a filtered sample");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.sample_out == OUT_MAX) || (m_data.sample_out == OUT_MIN))
        else $error("saturated flag with an unclipped value");

endmodule

bind fir_filter_16bit_audio_top fir16_checker u_fir16_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
